### sv/swkc_pkg.sv
// Package for the sliding-window key counter: sizes, field widths and helpers.
// No dependencies.
package swkc_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int COUNT_BITS    = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int KEY_W         = 64;
    localparam int REPORT_W      = 16;

    typedef logic [KEY_W-1:0]      key_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [IDX_W:0]        scan_t;
    typedef logic [REPORT_W-1:0]   report_t;

    localparam key_t    NEG_ZERO   = {1'b1, {(KEY_W-1){1'b0}}};
    localparam count_t  COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam count_t  COUNT_ONE  = count_t'(1);
    localparam report_t REPORT_MAX = {REPORT_W{1'b1}};

    // negative zero compares equal to zero
    function automatic key_t norm_key(input key_t k);
        norm_key = (k == NEG_ZERO) ? '0 : k;
    endfunction

    // clamp a count to the reported width
    function automatic report_t sat_report(input count_t c);
        logic [32:0] wide;
        wide = 33'(c);
        sat_report = (wide > 33'(REPORT_MAX)) ? REPORT_MAX : wide[REPORT_W-1:0];
    endfunction

endpackage

### sv/sliding_window_key_counter.sv
// Sliding-window key counter: table of distinct keys with occurrence counts.
// Each transaction makes up to two linear scans of the key memory (evict, then insert),
// one entry a cycle; a hit ends its scan early. One transaction at a time: the next is
// accepted in ST_IDLE, entered in the same cycle as the result is registered. Reset
// (aresetn low, synchronous) clears the valid marks and control state; no clearing pass.
module sliding_window_key_counter (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] new_key, [127:64] old_key
    input  logic         s_tuser,   // [0] old_key_vld
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // [15:0] key_count
    output logic         m_tuser    // [0] table_full
);
    import swkc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN_E, ST_UPD_E, ST_SCAN_N, ST_UPD_N, ST_INS
    } state_t;

    // storage: keys and counts in synchronous RAMs, valid marks in flops
    key_t   key_mem [TABLE_ENTRIES];
    count_t cnt_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    state_t  state_reg, state_next;
    key_t    nk_reg, nk_next, ek_reg, ek_next;
    scan_t   idx_reg, idx_next;          // next address to issue
    logic    pend_reg, pend_next;        // a read is in flight
    idx_t    pend_idx_reg, pend_idx_next;
    idx_t    slot_reg, slot_next;
    logic    free_found_reg, free_found_next;
    idx_t    free_idx_reg, free_idx_next;
    logic    mv_reg, mv_next;
    report_t mcnt_reg, mcnt_next;
    logic    mfull_reg, mfull_next;

    key_t    key_rd_reg;
    count_t  cnt_rd_reg;

    logic    key_we, cnt_we;
    idx_t    wr_addr;
    count_t  cnt_wdata;
    idx_t    rd_addr;

    logic    issue, hit, miss, can_out;
    key_t    target;
    count_t  cnt_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mcnt_reg;
    assign m_tuser  = mfull_reg;

    assign can_out  = !mv_reg || m_tready;
    assign issue    = (idx_reg < scan_t'(TABLE_ENTRIES));
    assign rd_addr  = idx_reg[IDX_W-1:0];
    assign target   = (state_reg == ST_SCAN_E) ? ek_reg : nk_reg;
    assign hit      = pend_reg && valid_reg[pend_idx_reg] && (key_rd_reg == target);
    assign miss     = !pend_reg && !issue;
    assign cnt_inc  = (cnt_rd_reg < COUNT_MAX) ? cnt_rd_reg + COUNT_ONE : cnt_rd_reg;

    always_comb begin
        state_next      = state_reg;
        nk_next         = nk_reg;
        ek_next         = ek_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        slot_next       = slot_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        mv_next         = mv_reg && !m_tready;
        mcnt_next       = mcnt_reg;
        mfull_next      = mfull_reg;
        key_we          = 1'b0;
        cnt_we          = 1'b0;
        wr_addr         = slot_reg;
        cnt_wdata       = cnt_inc;

        case (state_reg)
            ST_IDLE: begin
                idx_next        = '0;
                free_found_next = 1'b0;
                if (s_tvalid) begin
                    nk_next    = norm_key(s_tdata[63:0]);
                    ek_next    = norm_key(s_tdata[127:64]);
                    state_next = s_tuser ? ST_SCAN_E : ST_SCAN_N;
                end
            end
            ST_SCAN_E, ST_SCAN_N: begin
                if (issue) begin
                    pend_next     = 1'b1;
                    pend_idx_next = rd_addr;
                    idx_next      = idx_reg + scan_t'(1);
                    if (state_reg == ST_SCAN_N && !free_found_reg && !valid_reg[rd_addr]) begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_addr;
                    end
                end
                if (hit) begin
                    // count of the hit entry is read from pend_idx in this cycle
                    pend_next     = 1'b0;
                    pend_idx_next = pend_idx_reg;
                    slot_next     = pend_idx_reg;
                    state_next    = (state_reg == ST_SCAN_E) ? ST_UPD_E : ST_UPD_N;
                end else if (miss) begin
                    idx_next   = '0;
                    state_next = (state_reg == ST_SCAN_E) ? ST_SCAN_N : ST_INS;
                end
            end
            ST_UPD_E: begin
                if (cnt_rd_reg <= COUNT_ONE) begin
                    valid_next[slot_reg] = 1'b0;
                end else begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rd_reg - COUNT_ONE;
                end
                idx_next        = '0;
                free_found_next = 1'b0;
                state_next      = ST_SCAN_N;
            end
            ST_UPD_N: begin
                if (can_out) begin
                    cnt_we     = 1'b1;
                    mv_next    = 1'b1;
                    mcnt_next  = sat_report(cnt_inc);
                    mfull_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_INS: begin
                if (can_out) begin
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                    if (free_found_reg) begin
                        key_we    = 1'b1;
                        cnt_we    = 1'b1;
                        wr_addr   = free_idx_reg;
                        cnt_wdata = COUNT_ONE;
                        valid_next[free_idx_reg] = 1'b1;
                        mcnt_next  = sat_report(COUNT_ONE);
                        mfull_next = 1'b0;
                    end else begin
                        mcnt_next  = '0;
                        mfull_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_addr] <= nk_reg;
        end
        key_rd_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[wr_addr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[pend_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            pend_reg       <= 1'b0;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            mv_reg         <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            pend_reg       <= pend_next;
            idx_reg        <= idx_next;
            free_found_reg <= free_found_next;
            mv_reg         <= mv_next;
        end
        nk_reg       <= nk_next;
        ek_reg       <= ek_next;
        pend_idx_reg <= pend_idx_next;
        slot_reg     <= slot_next;
        free_idx_reg <= free_idx_next;
        mcnt_reg     <= mcnt_next;
        mfull_reg    <= mfull_next;
    end

endmodule

### sv/swkc_checker.sv
// Port-level checks for sliding_window_key_counter, bound to the top level.
// Depends on nothing but the top-level ports.
module swkc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 16'd0)) else $error("full with count");

    a_stored_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata != 16'd0)) else $error("zero count");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready after accept");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result dropped");
endmodule

bind sliding_window_key_counter swkc_checker u_swkc_checker (.*);

### tb/sliding_window_key_counter_tb.sv
// Self-checking bench for the sliding-window key counter: a queue-fed stream
// driver, a result monitor and a scoreboard of predicted key counts.
// Depends on swkc_pkg and sliding_window_key_counter.
module sliding_window_key_counter_tb;
    import swkc_pkg::*;

    typedef struct {
        key_t new_key;
        key_t old_key;
        logic old_key_vld;
    } window_upd_t;

    typedef struct {
        report_t key_count;
        logic    table_full;
    } count_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic         m_tuser;

    sliding_window_key_counter dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state: own copy of the key table
    key_t   pk_key[TABLE_ENTRIES];
    count_t pk_cnt[TABLE_ENTRIES];
    bit     pk_vld[TABLE_ENTRIES];

    window_upd_t pending_upd[$];
    count_res_t  expected_counts[$];
    int          n_fail = 0;
    bit          stim_done = 0;
    int          hold_off = 0;   // long receiver stall, in cycles

    // key pool mixes a few hot keys, zero and negative zero
    key_t hot_keys[8];

    function automatic key_t canon(key_t k);
        return (k == {1'b1, 63'b0}) ? key_t'(0) : k;
    endfunction

    function automatic int lookup(key_t k);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (pk_vld[i] && pk_key[i] == k) return i;
        return -1;
    endfunction

    function automatic count_res_t predict_count(window_upd_t u);
        count_res_t r;
        key_t nk;
        key_t ek;
        int   s;
        nk = canon(u.new_key);
        ek = canon(u.old_key);
        if (u.old_key_vld) begin
            s = lookup(ek);
            if (s >= 0) begin
                if (pk_cnt[s] <= 1) pk_vld[s] = 0;
                else pk_cnt[s] = pk_cnt[s] - 1'b1;
            end
        end
        s = lookup(nk);
        if (s < 0) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (!pk_vld[i]) begin s = i; break; end
            if (s < 0) begin
                r.key_count = '0;
                r.table_full = 1'b1;
                return r;
            end
            pk_vld[s] = 1;
            pk_key[s] = nk;
            pk_cnt[s] = '0;
        end
        if (pk_cnt[s] != {COUNT_BITS{1'b1}}) pk_cnt[s] = pk_cnt[s] + 1'b1;
        r.key_count = (pk_cnt[s] > 16'hFFFF) ? 16'hFFFF : report_t'(pk_cnt[s]);
        r.table_full = 1'b0;
        return r;
    endfunction

    function automatic key_t rand_key();
        return {$urandom, $urandom};
    endfunction

    function automatic key_t pick_key(int mode);
        case (mode)
            0: return hot_keys[$urandom_range(0, 7)];
            1: return key_t'($urandom_range(0, 90));   // dense small set, can fill table
            default: return rand_key();
        endcase
    endfunction

    task automatic push_upd(key_t nk, key_t ek, logic ev);
        window_upd_t u;
        u.new_key = nk;
        u.old_key = ek;
        u.old_key_vld = ev;
        pending_upd.insert(pending_upd.size(), u);
    endtask

    // stimulus: directed corners, then windowed random streams
    initial begin
        key_t win[$];
        int   wlen;
        int   mode;
        key_t k;
        for (int i = 0; i < TABLE_ENTRIES; i++) pk_vld[i] = 0;
        hot_keys[0] = '0;
        hot_keys[1] = {1'b1, 63'b0};
        hot_keys[2] = '1;
        for (int i = 3; i < 8; i++) hot_keys[i] = rand_key();

        // directed: zero, negative zero, all ones, absent evict, same key evict+insert
        push_upd('0, '0, 1'b0);
        push_upd({1'b1, 63'b0}, '0, 1'b0);
        push_upd('1, '1, 1'b1);
        push_upd('1, 64'h1234, 1'b1);
        push_upd('0, {1'b1, 63'b0}, 1'b1);
        push_upd('0, '0, 1'b1);
        push_upd(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        push_upd(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
        // fill the table, then overflow
        for (int i = 0; i < TABLE_ENTRIES + 2; i++)
            push_upd(key_t'(64'h1000 + i), '1, 1'b0);
        push_upd(key_t'(64'h1000), key_t'(64'h1003), 1'b1);
        push_upd(key_t'(64'h9999), '0, 1'b0);
        push_upd(key_t'(64'h9999), key_t'(64'h1005), 1'b1);
        // drain the fill keys so the random part starts from a roomy table
        for (int i = 0; i < TABLE_ENTRIES; i++)
            push_upd(hot_keys[2], key_t'(64'h1000 + i), 1'b1);

        // random: a sliding window evicts what it inserted wlen items earlier
        while (pending_upd.size() < 1000) begin
            wlen = $urandom_range(1, 80);
            mode = $urandom_range(0, 2);
            win.delete();
            for (int j = 0; j < 40; j++) begin
                k = pick_key(mode);
                if ($urandom_range(0, 9) == 0)
                    push_upd(k, rand_key(), $urandom_range(0, 1) == 1);   // noise
                else if (win.size() >= wlen)
                    push_upd(k, win.pop_front(), 1'b1);
                else
                    push_upd(k, '0, 1'b0);
                win.insert(win.size(), k);
            end
            // empty the window again
            while (win.size() > 0)
                push_upd(hot_keys[2], win.pop_front(), 1'b1);
        end
    end

    // driver: random gap before each transaction, held until accepted
    int gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap <= $urandom_range(0, 19);
        end else if (s_tvalid && !s_tready) begin
            // hold
        end else begin
            if (s_tvalid && s_tready) begin
                expected_counts.insert(expected_counts.size(),
                                       predict_count(pending_upd.pop_front()));
            end
            if (s_tvalid && s_tready && pending_upd.size() > 0 && gap == 0 &&
                $urandom_range(0, 3) != 0) begin
                // back-to-back: keep valid high, present next item
                s_tdata <= {pending_upd[0].old_key, pending_upd[0].new_key};
                s_tuser <= pending_upd[0].old_key_vld;
                gap <= $urandom_range(0, 2) == 0 ? $urandom_range(0, 19) : 0;
            end else if (s_tvalid && s_tready) begin
                s_tvalid <= 1'b0;
            end else if (gap > 0) begin
                gap <= gap - 1;
            end else if (pending_upd.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pending_upd[0].old_key, pending_upd[0].new_key};
                s_tuser  <= pending_upd[0].old_key_vld;
                gap <= $urandom_range(0, 2) == 0 ? $urandom_range(0, 19) : 0;
            end else begin
                stim_done <= 1'b1;
            end
        end
    end

    // monitor: checks each result against the oldest prediction
    int stall = 0;
    int n_res = 0;
    always @(posedge aclk) begin
        count_res_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall <= $urandom_range(0, 19);
        end else begin
            if (m_tvalid && m_tready) begin
                n_res <= n_res + 1;
                if (expected_counts.size() == 0) begin
                    $error("unexpected result key_count=%0d", m_tdata);
                    n_fail++;
                end else begin
                    e = expected_counts.pop_front();
                    if (m_tdata !== e.key_count) begin
                        $error("key_count expected %0d actual %0d", e.key_count, m_tdata);
                        n_fail++;
                    end
                    if (m_tuser !== e.table_full) begin
                        $error("table_full expected %0b actual %0b", e.table_full, m_tuser);
                        n_fail++;
                    end
                end
            end
            if (n_res == 300 && hold_off == 0) begin
                hold_off <= 3000;     // long stall: input backs up meanwhile
                m_tready <= 1'b0;
            end else if (hold_off > 1) begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall <= stall - 1;
                m_tready <= 1'b0;
                if (hold_off == 1) hold_off <= -1;
            end else begin
                if (hold_off == 1) hold_off <= -1;
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    stall <= $urandom_range(0, 2) == 0 ? $urandom_range(0, 19) : 0;
            end
        end
    end

    // reset, then watch for completion or timeout
    initial begin
        int cyc;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        cyc = 0;
        while (!(stim_done && expected_counts.size() == 0) && cyc < 800000) begin
            @(posedge aclk);
            cyc++;
        end
        if (cyc >= 800000) begin
            $display("Simulation FAILED");
            $finish;
        end
        // latency tail: catches any stray late result
        repeat (2 * TABLE_ENTRIES + 50) @(posedge aclk);
        if (n_fail == 0 && expected_counts.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

### sliding_window_key_counter.f
sv/swkc_pkg.sv
sv/sliding_window_key_counter.sv
sv/swkc_checker.sv
tb/sliding_window_key_counter_tb.sv
